// ===== rtl/core/a20_pkg.sv =====
// Shared types, constants and codes for the A20-gated parity RAM.
`timescale 1ns / 1ps

package a20_pkg;

    localparam int unsigned RAM_BYTES  = 65536;
    localparam int unsigned ADDR_W     = $clog2(RAM_BYTES);

    localparam int unsigned OP_W       = 3;
    localparam int unsigned PHYS_W     = 32;
    localparam int unsigned SEG_W      = 16;
    localparam int unsigned ROFF_W     = 16;
    localparam int unsigned DATA_W     = 8;
    localparam int unsigned SIZE_W     = 17;
    localparam int unsigned TGT_W      = 16;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned SEG_SHIFT  = 4;
    localparam int unsigned A20_POS    = 20;
    localparam int unsigned WIDE_W     = PHYS_W + 1;

    localparam int unsigned CMD_DEPTH  = 2;
    localparam int unsigned OUT_DEPTH  = 4;

    localparam logic [DATA_W-1:0] A20_PORT_FLAG   = 8'h02;
    localparam int unsigned       A20_FLAG_POS    = 1;
    localparam logic [SIZE_W-1:0] INSTALLED_RESET = 17'h1_0000;

    localparam logic [OP_W-1:0] OP_READ_PHYS  = 3'd0;
    localparam logic [OP_W-1:0] OP_WRITE_PHYS = 3'd1;
    localparam logic [OP_W-1:0] OP_READ_REAL  = 3'd2;
    localparam logic [OP_W-1:0] OP_WRITE_REAL = 3'd3;
    localparam logic [OP_W-1:0] OP_READ_PORT  = 3'd4;
    localparam logic [OP_W-1:0] OP_WRITE_PORT = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_WRAP_POLICY    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INSTALLED_SIZE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PARITY_SPAN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_ENABLE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_BASE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_TARGET  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH  = 3'd6;

    typedef enum logic [1:0] {
        KIND_NONE      = 2'd0,
        KIND_READ      = 2'd1,
        KIND_WRITE     = 2'd2,
        KIND_PORT_READ = 2'd3
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t           kind;
        logic                in_range;
        logic                parity_cov;
        logic [ADDR_W-1:0]   offset;
        logic [DATA_W-1:0]   wdata;
        logic [PHYS_W-1:0]   addr;
        logic                last;
        logic                a20;
    } cmd_t;

    typedef struct packed {
        logic                status;
        logic [DATA_W-1:0]   read_data;
        logic                parity_fault;
        logic [PHYS_W-1:0]   fault_address;
    } result_t;

endpackage

// ===== rtl/core/a20_front.sv =====
// Front end: configuration registers, A20 gate, address decode and classification.
`timescale 1ns / 1ps

module a20_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic [a20_pkg::OP_W-1:0]       op,
    input  logic [a20_pkg::PHYS_W-1:0]     phys_address,
    input  logic [a20_pkg::SEG_W-1:0]      segment,
    input  logic [a20_pkg::ROFF_W-1:0]     real_offset,
    input  logic [a20_pkg::DATA_W-1:0]     write_data,
    input  logic                           access_last,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [a20_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [a20_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           clearing,
    input  logic                           q_full,
    output logic                           q_push,
    output a20_pkg::cmd_t                  q_cmd
);

    logic                          wrap_policy_reg;
    logic [a20_pkg::SIZE_W-1:0]    installed_size_reg;
    logic [a20_pkg::SIZE_W-1:0]    parity_span_reg;
    logic                          window_enable_reg;
    logic [a20_pkg::PHYS_W-1:0]    window_base_reg;
    logic [a20_pkg::TGT_W-1:0]     window_target_reg;
    logic [a20_pkg::SIZE_W-1:0]    window_length_reg;
    logic                          a20_on_reg;
    logic                          a20_on_next;

    logic                          a_valid_reg;
    logic                          a_valid_next;
    a20_pkg::cmd_kind_t            a_kind_reg;
    logic [a20_pkg::PHYS_W-1:0]    a_addr_reg;
    logic [a20_pkg::PHYS_W-1:0]    a_fold_reg;
    logic [a20_pkg::DATA_W-1:0]    a_wdata_reg;
    logic                          a_last_reg;
    logic                          a_a20_reg;

    logic                          accept;
    logic                          is_real;
    logic [a20_pkg::PHYS_W-1:0]    linear;
    logic [a20_pkg::PHYS_W-1:0]    raw_addr;
    logic [a20_pkg::PHYS_W-1:0]    folded;
    a20_pkg::cmd_kind_t            kind;

    logic [a20_pkg::PHYS_W-1:0]    diff;
    logic                          win_hit;
    logic [a20_pkg::WIDE_W-1:0]    off_full;
    logic [a20_pkg::WIDE_W-1:0]    inst_eff;
    logic [a20_pkg::WIDE_W-1:0]    span_eff;

    function automatic logic [a20_pkg::PHYS_W-1:0] fold_a20(
        input logic [a20_pkg::PHYS_W-1:0] addr,
        input logic                       gate_on,
        input logic                       policy
    );
        logic [a20_pkg::PHYS_W-1:0] res;
        res = addr;
        if (!gate_on)
        begin
            if (!policy || (addr[a20_pkg::PHYS_W-1:a20_pkg::A20_POS+1] == '0))
            begin
                res[a20_pkg::A20_POS] = 1'b0;
            end
        end
        return res;
    endfunction

    assign cfg_ready = 1'b1;
    assign full      = clearing || (a_valid_reg && q_full);
    assign accept    = push && !full;
    assign q_push    = a_valid_reg && !q_full;

    // Input side: real-mode linear address, A20 fold and operation class.
    always_comb
    begin
        is_real  = (op == a20_pkg::OP_READ_REAL) || (op == a20_pkg::OP_WRITE_REAL);
        linear   = (a20_pkg::PHYS_W'(segment) << a20_pkg::SEG_SHIFT)
                   + a20_pkg::PHYS_W'(real_offset);
        raw_addr = is_real ? linear : phys_address;
        folded   = fold_a20(raw_addr, a20_on_reg, wrap_policy_reg);
        unique case (op)
            a20_pkg::OP_READ_PHYS, a20_pkg::OP_READ_REAL:   kind = a20_pkg::KIND_READ;
            a20_pkg::OP_WRITE_PHYS, a20_pkg::OP_WRITE_REAL: kind = a20_pkg::KIND_WRITE;
            a20_pkg::OP_READ_PORT:                          kind = a20_pkg::KIND_PORT_READ;
            default:                                        kind = a20_pkg::KIND_NONE;
        endcase
        a20_on_next = a20_on_reg;
        if (accept && (op == a20_pkg::OP_WRITE_PORT))
        begin
            a20_on_next = write_data[a20_pkg::A20_FLAG_POS];
        end
        a_valid_next = a_valid_reg;
        if (accept)
        begin
            a_valid_next = 1'b1;
        end
        else if (q_push)
        begin
            a_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wrap_policy_reg    <= 1'b0;
            installed_size_reg <= a20_pkg::INSTALLED_RESET;
            parity_span_reg    <= '0;
            window_enable_reg  <= 1'b0;
            window_base_reg    <= '0;
            window_target_reg  <= '0;
            window_length_reg  <= '0;
            a20_on_reg         <= 1'b0;
            a_valid_reg        <= 1'b0;
        end
        else
        begin
            a20_on_reg  <= a20_on_next;
            a_valid_reg <= a_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    a20_pkg::CFG_WRAP_POLICY:    wrap_policy_reg    <= cfg_data[0];
                    a20_pkg::CFG_INSTALLED_SIZE:
                        installed_size_reg <= cfg_data[a20_pkg::SIZE_W-1:0];
                    a20_pkg::CFG_PARITY_SPAN:
                        parity_span_reg    <= cfg_data[a20_pkg::SIZE_W-1:0];
                    a20_pkg::CFG_WINDOW_ENABLE:  window_enable_reg  <= cfg_data[0];
                    a20_pkg::CFG_WINDOW_BASE:
                        window_base_reg    <= cfg_data[a20_pkg::PHYS_W-1:0];
                    a20_pkg::CFG_WINDOW_TARGET:
                        window_target_reg  <= cfg_data[a20_pkg::TGT_W-1:0];
                    a20_pkg::CFG_WINDOW_LENGTH:
                        window_length_reg  <= cfg_data[a20_pkg::SIZE_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_kind_reg  <= kind;
            a_addr_reg  <= is_real ? folded : phys_address;
            a_fold_reg  <= folded;
            a_wdata_reg <= write_data;
            a_last_reg  <= access_last;
            a_a20_reg   <= a20_on_reg;
        end
    end

    // Second step: remap window, backing offset, range and parity coverage.
    always_comb
    begin
        diff    = a_addr_reg - window_base_reg;
        win_hit = window_enable_reg && (a_addr_reg >= window_base_reg)
                  && (diff[a20_pkg::PHYS_W-1:a20_pkg::SIZE_W] == '0)
                  && (diff[a20_pkg::SIZE_W-1:0] < window_length_reg);
        if (win_hit)
        begin
            off_full = a20_pkg::WIDE_W'(window_target_reg)
                       + a20_pkg::WIDE_W'(diff[a20_pkg::SIZE_W-1:0]);
        end
        else
        begin
            off_full = a20_pkg::WIDE_W'(a_fold_reg);
        end
        inst_eff = (a20_pkg::WIDE_W'(installed_size_reg) > a20_pkg::WIDE_W'(a20_pkg::RAM_BYTES))
                   ? a20_pkg::WIDE_W'(a20_pkg::RAM_BYTES)
                   : a20_pkg::WIDE_W'(installed_size_reg);
        span_eff = (a20_pkg::WIDE_W'(parity_span_reg) > a20_pkg::WIDE_W'(a20_pkg::RAM_BYTES))
                   ? a20_pkg::WIDE_W'(a20_pkg::RAM_BYTES)
                   : a20_pkg::WIDE_W'(parity_span_reg);
        q_cmd.kind       = a_kind_reg;
        q_cmd.in_range   = off_full < inst_eff;
        q_cmd.parity_cov = off_full < span_eff;
        q_cmd.offset     = off_full[a20_pkg::ADDR_W-1:0];
        q_cmd.wdata      = a_wdata_reg;
        q_cmd.addr       = a_addr_reg;
        q_cmd.last       = a_last_reg;
        q_cmd.a20        = a_a20_reg;
    end

endmodule

// ===== rtl/core/a20_cmd_fifo.sv =====
// Short command queue between the front end and the memory back end.
`timescale 1ns / 1ps

module a20_cmd_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  a20_pkg::cmd_t wr_cmd,
    output logic          q_full,
    input  logic          rd_en,
    output a20_pkg::cmd_t rd_cmd,
    output logic          q_empty
);

    localparam int unsigned PTR_W = $clog2(a20_pkg::CMD_DEPTH);
    localparam int unsigned CNT_W = $clog2(a20_pkg::CMD_DEPTH + 1);

    a20_pkg::cmd_t    entry_reg [a20_pkg::CMD_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_wr;
    logic             do_rd;

    assign q_full  = (count_reg == CNT_W'(a20_pkg::CMD_DEPTH));
    assign q_empty = (count_reg == '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_cmd  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(a20_pkg::CMD_DEPTH - 1)) ? '0
                          : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(a20_pkg::CMD_DEPTH - 1)) ? '0
                          : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

// ===== rtl/core/a20_back.sv =====
// Back end: byte and parity memories, clearing pass, parity check and result queue.
`timescale 1ns / 1ps

module a20_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_empty,
    input  a20_pkg::cmd_t                q_cmd,
    output logic                         q_pop,
    output logic                         clearing,
    output logic                         empty,
    input  logic                         pop,
    output logic                         status,
    output logic [a20_pkg::DATA_W-1:0]   read_data,
    output logic                         parity_fault,
    output logic [a20_pkg::PHYS_W-1:0]   fault_address
);

    localparam int unsigned OPTR_W = $clog2(a20_pkg::OUT_DEPTH);
    localparam int unsigned OCNT_W = $clog2(a20_pkg::OUT_DEPTH + 1);

    logic [a20_pkg::DATA_W-1:0] ram_mem [a20_pkg::RAM_BYTES];
    logic                       par_mem [a20_pkg::RAM_BYTES];
    logic [a20_pkg::DATA_W-1:0] ram_q_reg;
    logic                       par_q_reg;

    logic                       clr_active_reg;
    logic                       clr_active_next;
    logic [a20_pkg::ADDR_W-1:0] clr_addr_reg;
    logic [a20_pkg::ADDR_W-1:0] clr_addr_next;

    logic                       s2_valid_reg;
    a20_pkg::cmd_t              s2_cmd_reg;
    logic                       fault_seen_reg;
    logic                       fault_seen_next;

    logic                       ram_we;
    logic                       par_we;
    logic [a20_pkg::ADDR_W-1:0] waddr;
    logic [a20_pkg::DATA_W-1:0] wbyte;
    logic                       wpar;
    logic                       is_read;
    logic                       mismatch;
    a20_pkg::result_t           res;

    a20_pkg::result_t           out_reg [a20_pkg::OUT_DEPTH];
    logic [OPTR_W-1:0]          owr_ptr_reg;
    logic [OPTR_W-1:0]          ord_ptr_reg;
    logic [OCNT_W-1:0]          ocount_reg;
    logic [OCNT_W-1:0]          ocount_next;
    logic                       out_pop;
    a20_pkg::result_t           head;

    assign clearing = clr_active_reg;

    // A command issues only if the result queue has room for it and the one in flight.
    assign q_pop = !clr_active_reg && !q_empty
                   && ((OCNT_W + 1)'(ocount_reg) + (OCNT_W + 1)'(s2_valid_reg)
                       < (OCNT_W + 1)'(a20_pkg::OUT_DEPTH));

    always_comb
    begin
        clr_active_next = clr_active_reg;
        clr_addr_next   = clr_addr_reg;
        if (clr_active_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == a20_pkg::ADDR_W'(a20_pkg::RAM_BYTES - 1))
            begin
                clr_active_next = 1'b0;
            end
        end
        if (clr_active_reg)
        begin
            ram_we = 1'b1;
            par_we = 1'b1;
            waddr  = clr_addr_reg;
            wbyte  = '0;
            wpar   = 1'b0;
        end
        else
        begin
            ram_we = q_pop && (q_cmd.kind == a20_pkg::KIND_WRITE) && q_cmd.in_range;
            par_we = ram_we && q_cmd.parity_cov;
            waddr  = q_cmd.offset;
            wbyte  = q_cmd.wdata;
            wpar   = ^q_cmd.wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ram_we)
        begin
            ram_mem[waddr] <= wbyte;
        end
        if (q_pop)
        begin
            ram_q_reg <= ram_mem[q_cmd.offset];
        end
    end

    always_ff @(posedge clk)
    begin
        if (par_we)
        begin
            par_mem[waddr] <= wpar;
        end
        if (q_pop)
        begin
            par_q_reg <= par_mem[q_cmd.offset];
        end
    end

    // Result of the command whose memory data has just arrived.
    always_comb
    begin
        is_read  = (s2_cmd_reg.kind == a20_pkg::KIND_READ) && s2_cmd_reg.in_range;
        mismatch = is_read && s2_cmd_reg.parity_cov && (par_q_reg != (^ram_q_reg));
        res.status        = ((s2_cmd_reg.kind == a20_pkg::KIND_READ)
                             || (s2_cmd_reg.kind == a20_pkg::KIND_WRITE))
                            && !s2_cmd_reg.in_range;
        res.parity_fault  = mismatch && !fault_seen_reg;
        res.fault_address = res.parity_fault ? s2_cmd_reg.addr : '0;
        if (is_read)
        begin
            res.read_data = ram_q_reg;
        end
        else if ((s2_cmd_reg.kind == a20_pkg::KIND_PORT_READ) && s2_cmd_reg.a20)
        begin
            res.read_data = a20_pkg::A20_PORT_FLAG;
        end
        else
        begin
            res.read_data = '0;
        end
        fault_seen_next = fault_seen_reg;
        if (s2_valid_reg)
        begin
            if (s2_cmd_reg.last)
            begin
                fault_seen_next = 1'b0;
            end
            else if (res.parity_fault)
            begin
                fault_seen_next = 1'b1;
            end
        end
    end

    assign out_pop       = pop && (ocount_reg != '0);
    assign empty         = (ocount_reg == '0);
    assign head          = out_reg[ord_ptr_reg];
    assign status        = head.status;
    assign read_data     = head.read_data;
    assign parity_fault  = head.parity_fault;
    assign fault_address = head.fault_address;

    always_comb
    begin
        ocount_next = ocount_reg;
        if (s2_valid_reg && !out_pop)
        begin
            ocount_next = ocount_reg + 1'b1;
        end
        else if (out_pop && !s2_valid_reg)
        begin
            ocount_next = ocount_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            s2_valid_reg   <= 1'b0;
            fault_seen_reg <= 1'b0;
            owr_ptr_reg    <= '0;
            ord_ptr_reg    <= '0;
            ocount_reg     <= '0;
        end
        else
        begin
            clr_active_reg <= clr_active_next;
            clr_addr_reg   <= clr_addr_next;
            s2_valid_reg   <= q_pop;
            fault_seen_reg <= fault_seen_next;
            ocount_reg     <= ocount_next;
            if (s2_valid_reg)
            begin
                owr_ptr_reg <= owr_ptr_reg + 1'b1;
            end
            if (out_pop)
            begin
                ord_ptr_reg <= ord_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            s2_cmd_reg <= q_cmd;
        end
        if (s2_valid_reg)
        begin
            out_reg[owr_ptr_reg] <= res;
        end
    end

endmodule

// ===== rtl/core/a20_gated_parity_ram.sv =====
// Top level of the A20-gated byte RAM with remap window and per-byte parity.
// Throughput: one request per cycle while full stays low, set by the single-port byte
// memory in the back end.
// Reset: control and configuration registers to their defaults, A20 gate off; then a
// clearing pass zeroes the byte and parity memories, with full held high meanwhile.
`timescale 1ns / 1ps

module a20_gated_parity_ram (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic [a20_pkg::OP_W-1:0]       op,
    input  logic [a20_pkg::PHYS_W-1:0]     phys_address,
    input  logic [a20_pkg::SEG_W-1:0]      segment,
    input  logic [a20_pkg::ROFF_W-1:0]     real_offset,
    input  logic [a20_pkg::DATA_W-1:0]     write_data,
    input  logic                           access_last,
    output logic                           empty,
    input  logic                           pop,
    output logic                           status,
    output logic [a20_pkg::DATA_W-1:0]     read_data,
    output logic                           parity_fault,
    output logic [a20_pkg::PHYS_W-1:0]     fault_address,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [a20_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [a20_pkg::CFG_DATA_W-1:0] cfg_data
);

    logic          clearing;
    logic          q_full;
    logic          q_empty;
    logic          q_push;
    logic          q_pop;
    a20_pkg::cmd_t front_cmd;
    a20_pkg::cmd_t back_cmd;

    a20_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .op           (op),
        .phys_address (phys_address),
        .segment      (segment),
        .real_offset  (real_offset),
        .write_data   (write_data),
        .access_last  (access_last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .clearing     (clearing),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_cmd        (front_cmd)
    );

    a20_cmd_fifo u_cmd_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_cmd  (front_cmd),
        .q_full  (q_full),
        .rd_en   (q_pop),
        .rd_cmd  (back_cmd),
        .q_empty (q_empty)
    );

    a20_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_cmd         (back_cmd),
        .q_pop         (q_pop),
        .clearing      (clearing),
        .empty         (empty),
        .pop           (pop),
        .status        (status),
        .read_data     (read_data),
        .parity_fault  (parity_fault),
        .fault_address (fault_address)
    );

endmodule

// ===== sim/a20_gated_parity_ram_test.sv =====
// Self-checking testbench for the A20-gated parity RAM: directed table, then random phases.
`timescale 1ns / 1ps

module a20_gated_parity_ram_test;

    import a20_pkg::*;

    localparam logic [OP_W-1:0]     OP_SPARE_6   = 3'd6;
    localparam logic [OP_W-1:0]     OP_SPARE_7   = 3'd7;
    localparam logic                STATUS_OK    = 1'b0;
    localparam logic                STATUS_RANGE = 1'b1;
    localparam logic [PHYS_W-1:0]   A20_BIT      = 1 << A20_POS;

    localparam int PHASES           = 12;
    localparam int ITEMS_PER_PHASE  = 45;
    localparam int PRESSURE_PHASE   = 4;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES    = 8;
    localparam int PRINT_LIMIT      = 100;
    localparam int TIMEOUT_NS       = 4_000_000;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [PHYS_W-1:0] phys_address;
        logic [SEG_W-1:0]  segment;
        logic [ROFF_W-1:0] real_offset;
        logic [DATA_W-1:0] write_data;
        logic              access_last;
    } access_t;

    typedef struct {
        bit                    is_cfg;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] val;
        access_t               acc;
        bit                    typed;
        result_t               want;
    } stim_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  push;
    logic                  full;
    logic [OP_W-1:0]       op;
    logic [PHYS_W-1:0]     phys_address;
    logic [SEG_W-1:0]      segment;
    logic [ROFF_W-1:0]     real_offset;
    logic [DATA_W-1:0]     write_data;
    logic                  access_last;
    logic                  empty;
    logic                  pop;
    logic                  status;
    logic [DATA_W-1:0]     read_data;
    logic                  parity_fault;
    logic [PHYS_W-1:0]     fault_address;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    bit [DATA_W-1:0]   mem_model [RAM_BYTES];
    bit                parity_model [RAM_BYTES];
    bit                a20_m;
    bit                fault_m;
    logic              wrap_m  = 1'b0;
    logic [SIZE_W-1:0] inst_m  = INSTALLED_RESET;
    logic [SIZE_W-1:0] span_m  = '0;
    logic              wen_m   = 1'b0;
    logic [PHYS_W-1:0] wbase_m = '0;
    logic [TGT_W-1:0]  wtgt_m  = '0;
    logic [SIZE_W-1:0] wlen_m  = '0;

    result_t   expected_results[$];
    stim_row_t directed_rows[$];

    int errors;
    int items_sent;
    int results_checked;
    int faults_expected;
    int range_expected;
    int full_stall_cycles;
    int burst_left;
    int hold_req;
    bit memory_cleared;

    a20_gated_parity_ram i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .op            (op),
        .phys_address  (phys_address),
        .segment       (segment),
        .real_offset   (real_offset),
        .write_data    (write_data),
        .access_last   (access_last),
        .empty         (empty),
        .pop           (pop),
        .status        (status),
        .read_data     (read_data),
        .parity_fault  (parity_fault),
        .fault_address (fault_address),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #2 clk = ~clk;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        errors++;
        if (errors <= PRINT_LIMIT)
            $display("mismatch in %s at %0t: got %h, expected %h", what, $time, got, want);
    endtask

    function automatic logic [PHYS_W-1:0] fold_a20_model(input logic [PHYS_W-1:0] addr);
        if (a20_m)
            return addr;
        if (wrap_m)
            return (addr >= A20_BIT && addr < 2 * A20_BIT) ? addr - A20_BIT : addr;
        return addr & ~A20_BIT;
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_WRAP_POLICY:    wrap_m  = val[0];
            CFG_INSTALLED_SIZE: inst_m  = val[SIZE_W-1:0];
            CFG_PARITY_SPAN:    span_m  = val[SIZE_W-1:0];
            CFG_WINDOW_ENABLE:  wen_m   = val[0];
            CFG_WINDOW_BASE:    wbase_m = val;
            CFG_WINDOW_TARGET:  wtgt_m  = val[TGT_W-1:0];
            CFG_WINDOW_LENGTH:  wlen_m  = val[SIZE_W-1:0];
            default: ;
        endcase
    endfunction

    // Works out the response to one byte request and updates the memory image.
    function automatic result_t predict_access(input access_t a);
        result_t           r;
        logic [PHYS_W-1:0] phys;
        logic [63:0]       off;
        logic [63:0]       delta;
        logic [63:0]       ram_lim;
        logic [63:0]       par_lim;
        logic [DATA_W-1:0] b;
        r = '0;
        phys = a.phys_address;
        ram_lim = (inst_m > RAM_BYTES) ? RAM_BYTES : inst_m;
        par_lim = (span_m > RAM_BYTES) ? RAM_BYTES : span_m;
        if (a.op == OP_READ_REAL || a.op == OP_WRITE_REAL)
            phys = fold_a20_model(({16'd0, a.segment} << SEG_SHIFT) + {16'd0, a.real_offset});
        case (a.op)
            OP_READ_PHYS, OP_WRITE_PHYS, OP_READ_REAL, OP_WRITE_REAL:
            begin
                off = {32'd0, fold_a20_model(phys)};
                delta = {32'd0, phys} - {32'd0, wbase_m};
                if (wen_m && phys >= wbase_m && delta + 64'd1 <= {47'd0, wlen_m})
                    off = {48'd0, wtgt_m} + delta;
                if (off >= ram_lim)
                begin
                    r.status = STATUS_RANGE;
                end
                else if (a.op == OP_WRITE_PHYS || a.op == OP_WRITE_REAL)
                begin
                    mem_model[off[ADDR_W-1:0]] = a.write_data;
                    if (off < par_lim)
                        parity_model[off[ADDR_W-1:0]] = ^a.write_data;
                end
                else
                begin
                    b = mem_model[off[ADDR_W-1:0]];
                    r.read_data = b;
                    if (off < par_lim && parity_model[off[ADDR_W-1:0]] != ^b && !fault_m)
                    begin
                        fault_m = 1'b1;
                        r.parity_fault = 1'b1;
                        r.fault_address = phys;
                    end
                end
            end
            OP_READ_PORT:  r.read_data = a20_m ? A20_PORT_FLAG : '0;
            OP_WRITE_PORT: a20_m = a.write_data[A20_FLAG_POS];
            default: ;
        endcase
        if (a.access_last)
            fault_m = 1'b0;
        return r;
    endfunction

    task automatic send_req(input access_t a, input bit typed, input result_t want);
        result_t predicted;
        op           = a.op;
        phys_address = a.phys_address;
        segment      = a.segment;
        real_offset  = a.real_offset;
        write_data   = a.write_data;
        access_last  = a.access_last;
        push         = 1'b1;
        @(posedge clk);
        while (full)
        begin
            if (memory_cleared)
                full_stall_cycles++;
            @(posedge clk);
        end
        memory_cleared = 1'b1;
        predicted = predict_access(a);
        if (typed)
            predicted = want;
        expected_results.push_back(predicted);
        if (predicted.parity_fault)
            faults_expected++;
        if (predicted.status == STATUS_RANGE)
            range_expected++;
        items_sent++;
        @(negedge clk);
    endtask

    task automatic idle_between(input bit no_gaps);
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 12);
            if (!no_gaps)
            begin
                push = 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge clk);
            end
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_index = idx;
        cfg_data  = val;
        cfg_valid = 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        apply_reg(idx, val);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic wait_drained();
        push = 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic add_req(input logic [OP_W-1:0] o, input logic [PHYS_W-1:0] pa,
                           input logic [SEG_W-1:0] sg, input logic [ROFF_W-1:0] ro,
                           input logic [DATA_W-1:0] wd, input logic lst);
        stim_row_t row;
        row = '{default: '0};
        row.acc.op = o;
        row.acc.phys_address = pa;
        row.acc.segment = sg;
        row.acc.real_offset = ro;
        row.acc.write_data = wd;
        row.acc.access_last = lst;
        directed_rows.push_back(row);
    endtask

    task automatic add_req_exp(input logic [OP_W-1:0] o, input logic [PHYS_W-1:0] pa,
                               input logic [SEG_W-1:0] sg, input logic [ROFF_W-1:0] ro,
                               input logic [DATA_W-1:0] wd, input logic lst,
                               input logic st, input logic [DATA_W-1:0] rd,
                               input logic pf, input logic [PHYS_W-1:0] fa);
        stim_row_t row;
        add_req(o, pa, sg, ro, wd, lst);
        row = directed_rows.pop_back();
        row.typed = 1'b1;
        row.want.status = st;
        row.want.read_data = rd;
        row.want.parity_fault = pf;
        row.want.fault_address = fa;
        directed_rows.push_back(row);
    endtask

    task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        stim_row_t row;
        row = '{default: '0};
        row.is_cfg = 1'b1;
        row.idx = idx;
        row.val = val;
        directed_rows.push_back(row);
    endtask

    task automatic build_directed_table();
        add_req_exp(OP_READ_PHYS,  32'h0000_0000, 16'h0000, 16'h0000, 8'h00, 1'b1,
                    STATUS_OK, 8'h00, 1'b0, 32'h0);
        add_req_exp(OP_WRITE_PHYS, 32'h0000_FFFF, 16'h0000, 16'h0000, 8'hFF, 1'b1,
                    STATUS_OK, 8'h00, 1'b0, 32'h0);
        add_req_exp(OP_READ_PHYS,  32'h0000_FFFF, 16'h0000, 16'h0000, 8'h00, 1'b1,
                    STATUS_OK, 8'hFF, 1'b0, 32'h0);
        add_req_exp(OP_READ_PHYS,  32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1,
                    STATUS_RANGE, 8'h00, 1'b0, 32'h0);
        add_req(OP_READ_PHYS, 32'h0010_FFFF, 16'h0000, 16'h0000, 8'h00, 1'b1);
        add_req_exp(OP_READ_PORT,  32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1,
                    STATUS_OK, 8'h00, 1'b0, 32'h0);
        add_req_exp(OP_WRITE_PORT, 32'h0000_0000, 16'h0000, 16'h0000, 8'hFD, 1'b1,
                    STATUS_OK, 8'h00, 1'b0, 32'h0);
        add_req_exp(OP_READ_PORT,  32'h0000_0000, 16'h0000, 16'h0000, 8'h00, 1'b1,
                    STATUS_OK, 8'h00, 1'b0, 32'h0);
        add_req_exp(OP_WRITE_PORT, 32'h0000_0000, 16'h0000, 16'h0000, 8'h02, 1'b1,
                    STATUS_OK, 8'h00, 1'b0, 32'h0);
        add_req_exp(OP_READ_PORT,  32'h0000_0000, 16'h0000, 16'h0000, 8'h00, 1'b1,
                    STATUS_OK, A20_PORT_FLAG, 1'b0, 32'h0);
        add_req_exp(OP_READ_PHYS,  32'h0010_FFFF, 16'h0000, 16'h0000, 8'h00, 1'b1,
                    STATUS_RANGE, 8'h00, 1'b0, 32'h0);
        add_req_exp(OP_WRITE_REAL, 32'h0000_0000, 16'hFFFF, 16'hFFFF, 8'h55, 1'b1,
                    STATUS_RANGE, 8'h00, 1'b0, 32'h0);
        add_req_exp(OP_WRITE_REAL, 32'h0000_0000, 16'h0800, 16'h0123, 8'hAA, 1'b1,
                    STATUS_OK, 8'h00, 1'b0, 32'h0);
        add_req_exp(OP_WRITE_PORT, 32'h0000_0000, 16'h0000, 16'h0000, 8'h00, 1'b1,
                    STATUS_OK, 8'h00, 1'b0, 32'h0);
        add_req(OP_READ_REAL, 32'h0000_0000, 16'hFFFF, 16'h0010, 8'h00, 1'b1);
        add_req(OP_READ_REAL, 32'h0000_0000, 16'h0800, 16'h0123, 8'h00, 1'b1);
        add_req_exp(OP_SPARE_6,    32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1,
                    STATUS_OK, 8'h00, 1'b0, 32'h0);
        add_req_exp(OP_SPARE_7,    32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b0,
                    STATUS_OK, 8'h00, 1'b0, 32'h0);
        add_cfg(CFG_WRAP_POLICY, 32'd1);
        add_req(OP_READ_REAL, 32'h0000_0000, 16'hFFFF, 16'hFFFF, 8'h00, 1'b1);
        add_req_exp(OP_READ_PHYS,  32'h0030_0000, 16'h0000, 16'h0000, 8'h00, 1'b1,
                    STATUS_RANGE, 8'h00, 1'b0, 32'h0);
        // A byte written while parity is off, then read with parity on, must fault once.
        add_req_exp(OP_WRITE_PHYS, 32'h0000_0010, 16'h0000, 16'h0000, 8'h01, 1'b1,
                    STATUS_OK, 8'h00, 1'b0, 32'h0);
        add_cfg(CFG_PARITY_SPAN, 32'd65536);
        add_req_exp(OP_READ_PHYS,  32'h0000_0010, 16'h0000, 16'h0000, 8'h00, 1'b0,
                    STATUS_OK, 8'h01, 1'b1, 32'h0000_0010);
        add_req_exp(OP_READ_PHYS,  32'h0000_0010, 16'h0000, 16'h0000, 8'h00, 1'b1,
                    STATUS_OK, 8'h01, 1'b0, 32'h0);
        add_cfg(CFG_WINDOW_BASE, 32'hFFFF_0000);
        add_cfg(CFG_WINDOW_TARGET, 32'h0000_0010);
        add_cfg(CFG_WINDOW_LENGTH, 32'd65536);
        add_cfg(CFG_WINDOW_ENABLE, 32'd1);
        add_req(OP_READ_PHYS, 32'hFFFF_0000, 16'h0000, 16'h0000, 8'h00, 1'b1);
        add_req(OP_READ_PHYS, 32'hFFFF_FFFF, 16'h0000, 16'h0000, 8'h00, 1'b1);
        add_cfg(CFG_INSTALLED_SIZE, 32'd1);
        add_req_exp(OP_READ_PHYS,  32'h0000_0001, 16'h0000, 16'h0000, 8'h00, 1'b1,
                    STATUS_RANGE, 8'h00, 1'b0, 32'h0);
    endtask

    task automatic config_phase(input int p);
        case (p)
            0:
            begin
                write_reg(CFG_WRAP_POLICY, 32'd0);
                write_reg(CFG_INSTALLED_SIZE, 32'd1);
                write_reg(CFG_PARITY_SPAN, 32'd0);
                write_reg(CFG_WINDOW_ENABLE, 32'd0);
                write_reg(CFG_WINDOW_BASE, 32'h0);
                write_reg(CFG_WINDOW_TARGET, 32'h0);
                write_reg(CFG_WINDOW_LENGTH, 32'd0);
            end
            1:
            begin
                write_reg(CFG_WRAP_POLICY, 32'd1);
                write_reg(CFG_INSTALLED_SIZE, 32'd65536);
                write_reg(CFG_PARITY_SPAN, 32'd65536);
                write_reg(CFG_WINDOW_ENABLE, 32'd1);
                write_reg(CFG_WINDOW_BASE, 32'hFFFF_FFFF);
                write_reg(CFG_WINDOW_TARGET, 32'h0000_FFFF);
                write_reg(CFG_WINDOW_LENGTH, 32'd65536);
            end
            2:
            begin
                write_reg(CFG_WRAP_POLICY, 32'd0);
                write_reg(CFG_INSTALLED_SIZE, 32'h1_FFFF);
                write_reg(CFG_PARITY_SPAN, 32'h1_FFFF);
                write_reg(CFG_WINDOW_ENABLE, 32'd1);
                write_reg(CFG_WINDOW_BASE, 32'h000F_FF80);
                write_reg(CFG_WINDOW_TARGET, 32'h0);
                write_reg(CFG_WINDOW_LENGTH, 32'd256);
            end
            default:
            begin
                write_reg(CFG_WRAP_POLICY, $urandom_range(0, 1));
                case ($urandom_range(0, 4))
                    0: write_reg(CFG_INSTALLED_SIZE, 32'd65536);
                    1: write_reg(CFG_INSTALLED_SIZE, 32'h1_FFFF);
                    2: write_reg(CFG_INSTALLED_SIZE, $urandom_range(256, 65536));
                    3: write_reg(CFG_INSTALLED_SIZE, $urandom_range(1, 300));
                    default: write_reg(CFG_INSTALLED_SIZE, 32'd65536);
                endcase
                case ($urandom_range(0, 4))
                    0: write_reg(CFG_PARITY_SPAN, 32'd0);
                    1: write_reg(CFG_PARITY_SPAN, 32'd65536);
                    2: write_reg(CFG_PARITY_SPAN, $urandom_range(1, 256));
                    3: write_reg(CFG_PARITY_SPAN, $urandom_range(1, 65536));
                    default: write_reg(CFG_PARITY_SPAN, 32'h1_FFFF);
                endcase
                write_reg(CFG_WINDOW_ENABLE, $urandom_range(0, 1));
                case ($urandom_range(0, 4))
                    0: write_reg(CFG_WINDOW_BASE, 32'h0);
                    1: write_reg(CFG_WINDOW_BASE, 32'hFFFF_FFFF - $urandom_range(0, 255));
                    2: write_reg(CFG_WINDOW_BASE, 32'h000F_FF00 + $urandom_range(0, 511));
                    3: write_reg(CFG_WINDOW_BASE, $urandom);
                    default: write_reg(CFG_WINDOW_BASE, $urandom_range(0, 1023));
                endcase
                case ($urandom_range(0, 2))
                    0: write_reg(CFG_WINDOW_TARGET, $urandom_range(0, 255));
                    1: write_reg(CFG_WINDOW_TARGET, 32'h0000_FFFF - $urandom_range(0, 255));
                    default: write_reg(CFG_WINDOW_TARGET, $urandom_range(0, 65535));
                endcase
                case ($urandom_range(0, 3))
                    0: write_reg(CFG_WINDOW_LENGTH, 32'd0);
                    1: write_reg(CFG_WINDOW_LENGTH, $urandom_range(1, 512));
                    2: write_reg(CFG_WINDOW_LENGTH, 32'd65536);
                    default: write_reg(CFG_WINDOW_LENGTH, $urandom_range(1, 65536));
                endcase
            end
        endcase
    endtask

    function automatic logic [ADDR_W-1:0] pick_offset();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return $urandom_range(0, 255);
            6, 7:             return 16'hFFFF - $urandom_range(0, 63);
            8:                return wtgt_m + $urandom_range(0, 63);
            default:          return $urandom_range(0, 65535);
        endcase
    endfunction

    function automatic logic [PHYS_W-1:0] pick_phys(input logic [ADDR_W-1:0] offset);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return {16'd0, offset};
            5, 6:          return {16'd0, offset} | A20_BIT;
            7:             return wbase_m + $urandom_range(0, 300);
            8:             return wbase_m + wlen_m - $urandom_range(0, 3);
            default:       return $urandom;
        endcase
    endfunction

    // Most requests form accesses of one to four consecutive bytes; the rest are noise.
    task automatic send_random_access(input bit no_gaps);
        access_t     a;
        result_t     none;
        int          kind;
        int          len;
        bit          is_write;
        bit          is_real;
        logic [20:0] addr20;
        logic [16:0] seg_hi;
        int          k;
        none = '0;
        a.phys_address = $urandom;
        a.segment      = $urandom;
        a.real_offset  = $urandom;
        a.write_data   = $urandom;
        kind = $urandom_range(0, 99);
        if (kind < 12)
        begin
            a.op = $urandom_range(0, 7);
            a.access_last = $urandom_range(0, 1);
            send_req(a, 1'b0, none);
            idle_between(no_gaps);
        end
        else if (kind < 20)
        begin
            a.op = $urandom_range(0, 1) ? OP_WRITE_PORT : OP_READ_PORT;
            a.access_last = 1'b1;
            send_req(a, 1'b0, none);
            idle_between(no_gaps);
        end
        else
        begin
            len = $urandom_range(1, 4);
            is_write = $urandom_range(0, 1);
            is_real = $urandom_range(0, 1);
            if (is_real)
            begin
                a.op = is_write ? OP_WRITE_REAL : OP_READ_REAL;
                if ($urandom_range(0, 7) == 0)
                    addr20 = $urandom_range(0, 21'h10FFEF);
                else if ($urandom_range(0, 3) == 0)
                    addr20 = {5'd0, pick_offset()} + 21'h100000;
                else
                    addr20 = {5'd0, pick_offset()};
                if (addr20 > 21'h10FFEF)
                    addr20 = 21'h10FFEF;
                seg_hi = addr20[20:4];
                if (seg_hi > 17'h0FFFF)
                begin
                    a.segment = 16'hFFFF;
                    a.real_offset = addr20 - 21'h0FFFF0;
                end
                else
                begin
                    k = $urandom_range(0, (seg_hi > 4095) ? 4095 : seg_hi);
                    a.segment = seg_hi - k;
                    a.real_offset = addr20 - {1'b0, a.segment, 4'd0};
                end
            end
            else
            begin
                a.op = is_write ? OP_WRITE_PHYS : OP_READ_PHYS;
                a.phys_address = pick_phys(pick_offset());
            end
            for (int i = 0; i < len; i++)
            begin
                a.access_last = (i == len - 1);
                a.write_data = $urandom;
                send_req(a, 1'b0, none);
                idle_between(no_gaps);
                a.phys_address = a.phys_address + 1;
                a.real_offset = a.real_offset + 1;
            end
        end
    endtask

    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && pop && !empty)
        begin
            if (expected_results.size() == 0)
            begin
                report_mismatch("unexpected result, fault_address", fault_address, 32'h0);
            end
            else
            begin
                want = expected_results.pop_front();
                results_checked++;
                if (status !== want.status)
                    report_mismatch("status", status, want.status);
                if (read_data !== want.read_data)
                    report_mismatch("read_data", read_data, want.read_data);
                if (parity_fault !== want.parity_fault)
                    report_mismatch("parity_fault", parity_fault, want.parity_fault);
                if (fault_address !== want.fault_address)
                    report_mismatch("fault_address", fault_address, want.fault_address);
            end
        end
    end

    initial
    begin : receiver
        int hold_left;
        int pat_left;
        int pat_mode;
        hold_left = 0;
        pat_left = 0;
        pat_mode = 0;
        pop = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req != 0)
            begin
                hold_left = hold_req;
                hold_req = 0;
            end
            if (hold_left > 0)
            begin
                pop = 1'b0;
                hold_left--;
            end
            else
            begin
                if (pat_left == 0)
                begin
                    pat_mode = $urandom_range(0, 3);
                    pat_left = $urandom_range(8, 80);
                end
                pat_left--;
                case (pat_mode)
                    0:       pop = 1'b1;
                    1:       pop = $urandom_range(0, 1);
                    2:       pop = ($urandom_range(0, 3) == 0);
                    default: pop = (pat_left % 3 != 0);
                endcase
            end
        end
    end

    initial
    begin : watchdog
        #(TIMEOUT_NS);
        $display("** a20_gated_parity_ram: FAILED **");
        $finish;
    end

    initial
    begin : stimulus
        int phase_end;
        rst_n        = 1'b0;
        push         = 1'b0;
        op           = OP_READ_PHYS;
        phys_address = '0;
        segment      = '0;
        real_offset  = '0;
        write_data   = '0;
        access_last  = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_WRAP_POLICY;
        cfg_data     = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        build_directed_table();
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].is_cfg)
            begin
                wait_drained();
                write_reg(directed_rows[i].idx, directed_rows[i].val);
            end
            else
            begin
                send_req(directed_rows[i].acc, directed_rows[i].typed, directed_rows[i].want);
                idle_between(1'b0);
            end
        end

        for (int p = 0; p < PHASES; p++)
        begin
            wait_drained();
            config_phase(p);
            // The receiver holds off here while requests keep coming, so the block fills up.
            if (p == PRESSURE_PHASE)
                hold_req = LONG_HOLD_CYCLES;
            phase_end = items_sent + ITEMS_PER_PHASE;
            while (items_sent < phase_end)
                send_random_access(p == PRESSURE_PHASE);
        end

        wait_drained();
        if (expected_results.size() != 0)
            report_mismatch("results still outstanding", expected_results.size(), 32'h0);

        $display("Run covered %0d requests over %0d settings, %0d responses checked.",
                 items_sent, PHASES + 1, results_checked);
        $display("Expected %0d parity faults and %0d range errors; full held input %0d cycles.",
                 faults_expected, range_expected, full_stall_cycles);
        if (errors == 0)
            $display("** a20_gated_parity_ram: PASSED **");
        else
            $display("** a20_gated_parity_ram: FAILED **");
        $finish;
    end

endmodule
